FILE: hw/rtl/detp_pkg.sv
// Shared types, constants and helpers for the diffuse energy time propagation block.
package detp_pkg;

  // Fixed field widths
  localparam int unsigned E_W      = 48;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned DLY_W    = 10;
  localparam int unsigned TIME_W   = 10;
  localparam int unsigned TRI_IO_W = 6;
  localparam int unsigned TC_W     = 7;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Defaults for the top level parameters
  localparam int unsigned MAX_TRIANGLES_DEF = 64;
  localparam int unsigned MAX_BINS_DEF      = 1024;

  // Fixed point constants
  localparam logic [FRAC_W-1:0] ONE_FRAC  = 17'd65536;
  localparam logic [FRAC_W-1:0] ABS_RESET = 17'd13107;
  localparam int unsigned       DUR_LIMIT = 1000;
  localparam logic [E_W-1:0]    E_MAX     = {E_W{1'b1}};

  // Configuration register reset values
  localparam logic [TC_W-1:0]   TC_RESET  = 7'd1;
  localparam logic [TIME_W-1:0] DUR_RESET = 10'd1000;
  localparam logic [E_W-1:0]    BF_RESET  = 48'd1100;
  localparam logic [E_W-1:0]    CF_RESET  = 48'd110;

  typedef enum logic [OP_W-1:0] {
    OP_ABS   = 3'd0,
    OP_LINK  = 3'd1,
    OP_SEED  = 3'd2,
    OP_STEP  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRI_COUNT  = 2'd0,
    CFG_DURATION   = 2'd1,
    CFG_BIN_FLOOR  = 2'd2,
    CFG_CELL_FLOOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEED_WR,
    S_SUM,
    S_SUM_ACC,
    S_SUM_CHK,
    S_CELL,
    S_CELL_CHK,
    S_PEND,
    S_REFL_LO,
    S_REFL_HI,
    S_REFL_CHK,
    S_LINK,
    S_LINK_CHK,
    S_SHARE_LO,
    S_SHARE_HI,
    S_TGT_RD,
    S_TGT_WR,
    S_FINAL
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic abs_wr;
    logic link_wr;
    logic clr_init;
    logic clr_step;
    logic step_init;
    logic bin_adv;
    logic seed_rd;
    logic seed_wr;
    logic sum_rd;
    logic sum_acc;
    logic i_clr;
    logic i_inc;
    logic cell_rd;
    logic e_load;
    logic pend_shift;
    logic mul_lo;
    logic mul_hi;
    logic mul_share;
    logic link_rd;
    logic link_load;
    logic j_clr;
    logic j_inc;
    logic tgt_rd;
    logic tgt_wr;
    logic final_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic seed_ok;
    logic run_done;
    logic i_lt_n;
    logic j_lt_n;
    logic total_ok;
    logic e_ok;
    logic refl_ok;
    logic link_ok;
    logic pend_valid;
    logic out_free;
    logic clr_last;
  } status_t;

  // Saturating add of two Q8.40 values
  function automatic logic [E_W-1:0] sat_add(input logic [E_W-1:0] a,
                                             input logic [E_W-1:0] b);
    logic [E_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[E_W] ? E_MAX : s[E_W-1:0];
  endfunction

  // Fraction clamp to one
  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] v);
    return (v > ONE_FRAC) ? ONE_FRAC : v;
  endfunction

endpackage

FILE: hw/rtl/diffuse_energy_time_propagation.sv
// Top level of the diffuse energy time propagation block.
// Each request is one op. Absorption and link writes, spare ops and a rejected
// seed leave the arrival store alone; a stored seed reads its entry and writes
// it back. A step sums the bin total over the triangles in use and scans the
// cells only when that total reaches bin_floor. An emitted cell whose reflected
// energy reaches cell_floor walks its link row, and each visible link that lands
// in the run adds a share to its target. A step past the end of the run sends
// only the empty marker. Every store access goes through one read and one write
// port, and the step waits while a result is held by out_stall_i. Samples of a
// step leave one behind the scan, so the last one can carry last_of_bin. After
// reset, and after each clear-run op, a clearing pass writes zero to all
// MAX_BINS * MAX_TRIANGLES store entries, one per cycle, while no request is
// taken. Configuration is to be written only while no request is in flight;
// the block itself does not enforce this.
module diffuse_energy_time_propagation
  import detp_pkg::*;
#(
  parameter int unsigned MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int unsigned MAX_BINS      = MAX_BINS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [E_W-1:0]       cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [TRI_IO_W-1:0]  source_triangle_i,
  input  logic [TRI_IO_W-1:0]  target_triangle_i,
  input  logic                 link_visible_i,
  input  logic [DLY_W-1:0]     link_delay_i,
  input  logic [FRAC_W-1:0]    fraction_value_i,
  input  logic [TIME_W-1:0]    seed_time_i,
  input  logic [E_W-1:0]       seed_energy_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TRI_IO_W-1:0]  sample_triangle_o,
  output logic [TIME_W-1:0]    sample_time_o,
  output logic [E_W-1:0]       sample_energy_o,
  output logic                 sample_valid_o,
  output logic                 last_of_bin_o
);

  cmd_t    cmd;
  status_t st;

  detp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  detp_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .MAX_BINS      (MAX_BINS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .source_triangle_i (source_triangle_i),
    .target_triangle_i (target_triangle_i),
    .link_visible_i    (link_visible_i),
    .link_delay_i      (link_delay_i),
    .fraction_value_i  (fraction_value_i),
    .seed_time_i       (seed_time_i),
    .seed_energy_i     (seed_energy_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_triangle_o (sample_triangle_o),
    .sample_time_o     (sample_time_o),
    .sample_energy_o   (sample_energy_o),
    .sample_valid_o    (sample_valid_o),
    .last_of_bin_o     (last_of_bin_o)
  );

endmodule

FILE: hw/rtl/detp_ctrl.sv
// Sequencing state machine for the propagation block.
module detp_ctrl
  import detp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register; reset starts the store clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (st_i.op)
          OP_ABS:  cmd_o.abs_wr = 1'b1;
          OP_LINK: cmd_o.link_wr = 1'b1;
          OP_SEED: begin
            if (st_i.seed_ok) begin
              cmd_o.seed_rd = 1'b1;
              state_d       = S_SEED_WR;
            end
          end
          OP_CLEAR: begin
            cmd_o.clr_init = 1'b1;
            state_d        = S_CLEAR;
          end
          OP_STEP: begin
            cmd_o.step_init = 1'b1;
            cmd_o.i_clr     = 1'b1;
            if (st_i.run_done) begin
              state_d = S_FINAL;
            end else begin
              cmd_o.bin_adv = 1'b1;
              state_d       = S_SUM;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEED_WR: begin
        cmd_o.seed_wr = 1'b1;
        state_d       = S_IDLE;
      end
      // Bin total over the triangles in use
      S_SUM: begin
        if (st_i.i_lt_n) begin
          cmd_o.sum_rd = 1'b1;
          cmd_o.i_inc  = 1'b1;
          state_d      = S_SUM_ACC;
        end else begin
          state_d = S_SUM_CHK;
        end
      end
      S_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM_CHK: begin
        cmd_o.i_clr = 1'b1;
        state_d     = st_i.total_ok ? S_CELL : S_FINAL;
      end
      // Cell scan in ascending triangle order
      S_CELL: begin
        if (st_i.i_lt_n) begin
          cmd_o.cell_rd = 1'b1;
          state_d       = S_CELL_CHK;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_CELL_CHK: begin
        cmd_o.e_load = 1'b1;
        if (st_i.e_ok) begin
          state_d = S_PEND;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_CELL;
        end
      end
      S_PEND: begin
        if (!st_i.pend_valid || st_i.out_free) begin
          cmd_o.pend_shift = 1'b1;
          state_d          = S_REFL_LO;
        end
      end
      S_REFL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_REFL_HI;
      end
      S_REFL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_REFL_CHK;
      end
      S_REFL_CHK: begin
        cmd_o.j_clr = 1'b1;
        if (st_i.refl_ok) begin
          state_d = S_LINK;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_CELL;
        end
      end
      // Link walk for the current source cell
      S_LINK: begin
        if (st_i.j_lt_n) begin
          cmd_o.link_rd = 1'b1;
          state_d       = S_LINK_CHK;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_CELL;
        end
      end
      S_LINK_CHK: begin
        cmd_o.link_load = 1'b1;
        if (st_i.link_ok) begin
          state_d = S_SHARE_LO;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_LINK;
        end
      end
      S_SHARE_LO: begin
        cmd_o.mul_lo    = 1'b1;
        cmd_o.mul_share = 1'b1;
        state_d         = S_SHARE_HI;
      end
      S_SHARE_HI: begin
        cmd_o.mul_hi    = 1'b1;
        cmd_o.mul_share = 1'b1;
        state_d         = S_TGT_RD;
      end
      S_TGT_RD: begin
        cmd_o.tgt_rd = 1'b1;
        state_d      = S_TGT_WR;
      end
      S_TGT_WR: begin
        cmd_o.tgt_wr = 1'b1;
        cmd_o.j_inc  = 1'b1;
        state_d      = S_LINK;
      end
      // Last sample of the step or the empty marker
      S_FINAL: begin
        if (st_i.out_free) begin
          cmd_o.final_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/detp_dp.sv
// Datapath: configuration, tables, arrival store, multiplier and result register.
module detp_dp
  import detp_pkg::*;
#(
  parameter int unsigned MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int unsigned MAX_BINS      = MAX_BINS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              st_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [E_W-1:0]       cfg_data_i,
  input  logic [OP_W-1:0]      op_i,
  input  logic [TRI_IO_W-1:0]  source_triangle_i,
  input  logic [TRI_IO_W-1:0]  target_triangle_i,
  input  logic                 link_visible_i,
  input  logic [DLY_W-1:0]     link_delay_i,
  input  logic [FRAC_W-1:0]    fraction_value_i,
  input  logic [TIME_W-1:0]    seed_time_i,
  input  logic [E_W-1:0]       seed_energy_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TRI_IO_W-1:0]  sample_triangle_o,
  output logic [TIME_W-1:0]    sample_time_o,
  output logic [E_W-1:0]       sample_energy_o,
  output logic                 sample_valid_o,
  output logic                 last_of_bin_o
);

  localparam int unsigned TRI_W   = $clog2(MAX_TRIANGLES);
  localparam int unsigned CNT_W   = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned BIN_W   = $clog2(MAX_BINS);
  localparam int unsigned CB_W    = $clog2(MAX_BINS + 1);
  localparam int unsigned AT_W    = ((CB_W > DLY_W) ? CB_W : DLY_W) + 1;
  localparam int unsigned DEPTH   = MAX_BINS * MAX_TRIANGLES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned LDEPTH  = MAX_TRIANGLES * MAX_TRIANGLES;
  localparam int unsigned LADDR_W = $clog2(LDEPTH);
  localparam int unsigned LINK_W  = 1 + DLY_W + FRAC_W;
  localparam int unsigned DUR_CAP = (DUR_LIMIT < MAX_BINS - 1) ? DUR_LIMIT : MAX_BINS - 1;
  localparam int unsigned HALF_W  = E_W / 2;
  localparam int unsigned PROD_W  = HALF_W + FRAC_W;

  // Configuration registers
  logic [TC_W-1:0]   cfg_tc_q;
  logic [TIME_W-1:0] cfg_dur_q;
  logic [E_W-1:0]    cfg_bf_q;
  logic [E_W-1:0]    cfg_cf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tc_q  <= TC_RESET;
      cfg_dur_q <= DUR_RESET;
      cfg_bf_q  <= BF_RESET;
      cfg_cf_q  <= CF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TRI_COUNT:  cfg_tc_q  <= cfg_data_i[TC_W-1:0];
        CFG_DURATION:   cfg_dur_q <= cfg_data_i[TIME_W-1:0];
        CFG_BIN_FLOOR:  cfg_bf_q  <= cfg_data_i;
        CFG_CELL_FLOOR: cfg_cf_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective triangle count and duration
  logic [CNT_W-1:0]  n_eff;
  logic [TIME_W-1:0] dur_eff;
  assign n_eff   = (32'(cfg_tc_q) > MAX_TRIANGLES) ? CNT_W'(MAX_TRIANGLES) : CNT_W'(cfg_tc_q);
  assign dur_eff = (32'(cfg_dur_q) > DUR_CAP) ? TIME_W'(DUR_CAP) : cfg_dur_q;

  // Request capture
  logic [OP_W-1:0]     op_q;
  logic [TRI_IO_W-1:0] src_q, tgt_q;
  logic                vis_q;
  logic [DLY_W-1:0]    dly_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [TIME_W-1:0]   stime_q;
  logic [E_W-1:0]      senergy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_i;
      src_q     <= source_triangle_i;
      tgt_q     <= target_triangle_i;
      vis_q     <= link_visible_i;
      dly_q     <= link_delay_i;
      frac_q    <= clamp_frac(fraction_value_i);
      stime_q   <= seed_time_i;
      senergy_q <= seed_energy_i;
    end
  end

  // Bin and triangle counters
  logic [CB_W-1:0]   cur_bin_q, t_q;
  logic [CNT_W-1:0]  i_q, j_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_bin_q  <= '0;
      t_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.clr_init) cur_bin_q <= '0;
      else if (cmd_i.bin_adv) cur_bin_q <= cur_bin_q + 1'b1;
      if (cmd_i.step_init) t_q <= cur_bin_q;
      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + 1'b1;
      if (cmd_i.j_clr) j_q <= '0;
      else if (cmd_i.j_inc) j_q <= j_q + 1'b1;
      if (cmd_i.clr_init) clr_addr_q <= '0;
      else if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Absorption table with reset-value valid bits
  logic [FRAC_W-1:0]        abs_mem [MAX_TRIANGLES];
  logic [MAX_TRIANGLES-1:0] abs_vld_q;
  logic [FRAC_W-1:0]        abs_rd_q;
  logic                     abs_rd_vld_q;
  logic                     src_in_range;
  logic [FRAC_W-1:0]        abs_eff;

  assign src_in_range = (32'(src_q) < MAX_TRIANGLES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.abs_wr && src_in_range) abs_mem[TRI_W'(src_q)] <= frac_q;
    if (cmd_i.cell_rd) abs_rd_q <= abs_mem[i_q[TRI_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_vld_q    <= '0;
      abs_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.abs_wr && src_in_range) abs_vld_q[TRI_W'(src_q)] <= 1'b1;
      if (cmd_i.cell_rd) abs_rd_vld_q <= abs_vld_q[i_q[TRI_W-1:0]];
    end
  end

  assign abs_eff = abs_rd_vld_q ? abs_rd_q : ABS_RESET;

  // Link table: visible, delay, share
  logic [LINK_W-1:0]  link_mem [LDEPTH];
  logic [LINK_W-1:0]  link_rd_q;
  logic [LADDR_W-1:0] link_waddr, link_raddr;
  logic               link_idx_ok;

  assign link_idx_ok = src_in_range && (32'(tgt_q) < MAX_TRIANGLES);
  assign link_waddr  = LADDR_W'(src_q) * LADDR_W'(MAX_TRIANGLES) + LADDR_W'(tgt_q);
  assign link_raddr  = LADDR_W'(i_q) * LADDR_W'(MAX_TRIANGLES) + LADDR_W'(j_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr && link_idx_ok) link_mem[link_waddr] <= {vis_q, dly_q, frac_q};
    if (cmd_i.link_rd) link_rd_q <= link_mem[link_raddr];
  end

  logic              lk_vis;
  logic [DLY_W-1:0]  lk_dly;
  logic [FRAC_W-1:0] lk_shr;
  logic [AT_W-1:0]   lk_at;
  assign {lk_vis, lk_dly, lk_shr} = link_rd_q;
  assign lk_at = AT_W'(t_q) + AT_W'(lk_dly);

  logic [AT_W-1:0]   at_q;
  logic [FRAC_W-1:0] shr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.link_load) begin
      at_q  <= lk_at;
      shr_q <= lk_shr;
    end
  end

  // Arrival store: bin-major, one write and one read port
  logic [E_W-1:0]    st_mem [DEPTH];
  logic [E_W-1:0]    st_rd_q;
  logic [ADDR_W-1:0] seed_addr, cell_addr, tgt_addr, st_raddr, st_waddr;
  logic [E_W-1:0]    st_wdata;
  logic              st_rd, st_we;
  logic [E_W-1:0]    share_q;

  assign seed_addr = ADDR_W'(stime_q) * ADDR_W'(MAX_TRIANGLES) + ADDR_W'(src_q);
  assign cell_addr = ADDR_W'(t_q) * ADDR_W'(MAX_TRIANGLES) + ADDR_W'(i_q);
  assign tgt_addr  = ADDR_W'(at_q[BIN_W-1:0]) * ADDR_W'(MAX_TRIANGLES) + ADDR_W'(j_q);

  assign st_rd = cmd_i.seed_rd | cmd_i.sum_rd | cmd_i.cell_rd | cmd_i.tgt_rd;
  assign st_we = cmd_i.seed_wr | cmd_i.tgt_wr | cmd_i.clr_step;

  always_comb begin
    if (cmd_i.seed_rd) st_raddr = seed_addr;
    else if (cmd_i.tgt_rd) st_raddr = tgt_addr;
    else st_raddr = cell_addr;
  end

  always_comb begin
    if (cmd_i.clr_step) begin
      st_waddr = clr_addr_q;
      st_wdata = '0;
    end else if (cmd_i.seed_wr) begin
      st_waddr = seed_addr;
      st_wdata = sat_add(st_rd_q, senergy_q);
    end else begin
      st_waddr = tgt_addr;
      st_wdata = sat_add(st_rd_q, share_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_rd) st_rd_q <= st_mem[st_raddr];
  end

  // Bin total and cell energy
  logic [E_W-1:0] total_q, e_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_init) total_q <= '0;
    else if (cmd_i.sum_acc) total_q <= sat_add(total_q, st_rd_q);
    if (cmd_i.e_load) e_q <= st_rd_q;
  end

  // Fraction multiply: low half then high half, shared by reflection and share
  logic [FRAC_W-1:0] f_refl_q;
  logic [E_W-1:0]    refl_q;
  logic [E_W-1:0]    mul_e;
  logic [FRAC_W-1:0] mul_f;
  logic [PROD_W-1:0] prod_q, mul_p;
  logic [HALF_W-1:0] mul_half;
  logic [E_W+FRAC_W:0] mul_sum;
  logic [E_W-1:0]    mul_res;

  assign mul_e    = cmd_i.mul_share ? refl_q : e_q;
  assign mul_f    = cmd_i.mul_share ? shr_q : f_refl_q;
  assign mul_half = cmd_i.mul_lo ? mul_e[HALF_W-1:0] : mul_e[E_W-1:HALF_W];
  assign mul_p    = PROD_W'(mul_half) * PROD_W'(mul_f);
  assign mul_sum  = (E_W+FRAC_W+1)'(prod_q) + ((E_W+FRAC_W+1)'(mul_p) << HALF_W);
  assign mul_res  = (mul_f >= ONE_FRAC) ? mul_e : mul_sum[E_W+15:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_shift) f_refl_q <= ONE_FRAC - abs_eff;
    if (cmd_i.mul_lo) prod_q <= mul_p;
    if (cmd_i.mul_hi && !cmd_i.mul_share) refl_q <= mul_res;
    if (cmd_i.mul_hi && cmd_i.mul_share) share_q <= mul_res;
  end

  // Pending sample, held until it is known whether it ends the step
  logic [TRI_IO_W-1:0] pend_tri_q;
  logic [E_W-1:0]      pend_e_q;
  logic                pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.step_init) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_shift) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_shift) begin
      pend_tri_q <= TRI_IO_W'(i_q);
      pend_e_q   <= e_q;
    end
  end

  // Result register
  logic out_load, out_free;
  assign out_free = !out_valid_o || !out_stall_i;
  assign out_load = (cmd_i.pend_shift && pend_valid_q) || cmd_i.final_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_time_o <= TIME_W'(t_q);
      last_of_bin_o <= cmd_i.final_out;
      if (pend_valid_q) begin
        sample_triangle_o <= pend_tri_q;
        sample_energy_o   <= pend_e_q;
        sample_valid_o    <= 1'b1;
      end else begin
        sample_triangle_o <= '0;
        sample_energy_o   <= '0;
        sample_valid_o    <= 1'b0;
      end
    end
  end

  // Status
  assign st_o.op         = op_e'(op_q);
  assign st_o.seed_ok    = (32'(src_q) < 32'(n_eff)) && (stime_q <= dur_eff) &&
                           (senergy_q != '0);
  assign st_o.run_done   = (32'(cur_bin_q) > 32'(dur_eff));
  assign st_o.i_lt_n     = (i_q < n_eff);
  assign st_o.j_lt_n     = (j_q < n_eff);
  assign st_o.total_ok   = (total_q >= cfg_bf_q);
  assign st_o.e_ok       = (st_rd_q >= cfg_cf_q);
  assign st_o.refl_ok    = (refl_q >= cfg_cf_q);
  assign st_o.link_ok    = (j_q != i_q) && lk_vis && (32'(lk_at) <= 32'(dur_eff));
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;
  assign st_o.clr_last   = (clr_addr_q == ADDR_W'(DEPTH - 1));

  // Checks
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result loaded over a waiting result");
  a_store_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_rd && st_we)) else $error("store read and written in one cycle");
  a_pend_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pend_shift && pend_valid_q) |=> (out_valid_o && !sample_valid_o == 1'b0))
    else $error("pending sample not pushed");
  a_i_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.i_inc |-> (i_q < n_eff)) else $error("triangle counter past count");

endmodule

FILE: dv/diffuse_energy_time_propagation_tb.sv
// Self-checking testbench for the diffuse energy time propagation block.
module diffuse_energy_time_propagation_tb;
  import detp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTRI       = 64;
  localparam int unsigned NBIN       = 1024;
  localparam int unsigned CYCLE_LIMIT = 40000000;
  localparam int unsigned DRAIN_WAIT = 400;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [TRI_IO_W-1:0] src;
    logic [TRI_IO_W-1:0] tgt;
    logic                vis;
    logic [DLY_W-1:0]    dly;
    logic [FRAC_W-1:0]   frac;
    logic [TIME_W-1:0]   stime;
    logic [E_W-1:0]      energy;
  } request_t;

  typedef struct {
    logic [TRI_IO_W-1:0] tri_idx;
    logic [TIME_W-1:0]   bin;
    logic [E_W-1:0]      energy;
    logic                svalid;
    logic                last;
  } sample_t;

  // Energy propagation predictor and store of pending samples
  class energy_board;
    logic [E_W-1:0]    arrivals[NBIN*NTRI];
    logic              lk_vis[NTRI*NTRI];
    logic [DLY_W-1:0]  lk_dly[NTRI*NTRI];
    logic [FRAC_W-1:0] lk_share[NTRI*NTRI];
    logic              lk_set[NTRI*NTRI];
    logic [FRAC_W-1:0] absorb[NTRI];
    int unsigned       cur_bin;
    logic [TC_W-1:0]   tri_count;
    logic [TIME_W-1:0] dur_reg;
    logic [E_W-1:0]    bin_floor;
    logic [E_W-1:0]    cell_floor;
    sample_t           pending[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       steps;

    function new();
      foreach (arrivals[i]) arrivals[i] = '0;
      foreach (lk_vis[i]) begin
        lk_vis[i] = 1'b0;
        lk_dly[i] = '0;
        lk_share[i] = '0;
        lk_set[i] = 1'b0;
      end
      foreach (absorb[i]) absorb[i] = ABS_RESET;
      cur_bin = 0;
      tri_count = TC_RESET;
      dur_reg = DUR_RESET;
      bin_floor = BF_RESET;
      cell_floor = CF_RESET;
      errors = 0;
      checked = 0;
      steps = 0;
    endfunction

    function int unsigned active_count();
      return (tri_count > NTRI) ? NTRI : tri_count;
    endfunction

    function int unsigned last_bin();
      return (dur_reg > DUR_LIMIT) ? DUR_LIMIT : dur_reg;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [E_W-1:0] v);
      case (idx)
        CFG_TRI_COUNT:  tri_count = v[TC_W-1:0];
        CFG_DURATION:   dur_reg = v[TIME_W-1:0];
        CFG_BIN_FLOOR:  bin_floor = v;
        CFG_CELL_FLOOR: cell_floor = v;
        default: ;
      endcase
    endfunction

    function logic [E_W-1:0] add_sat(logic [E_W-1:0] a, logic [E_W-1:0] b);
      logic [E_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[E_W] ? {E_W{1'b1}} : s[E_W-1:0];
    endfunction

    function logic [E_W-1:0] scale(logic [E_W-1:0] e, logic [FRAC_W-1:0] f);
      logic [E_W+FRAC_W-1:0] p;
      if (f >= 17'd65536) return e;
      p = {{FRAC_W{1'b0}}, e} * {{E_W{1'b0}}, f};
      return p[E_W+15:16];
    endfunction

    function logic [FRAC_W-1:0] sat_frac(logic [FRAC_W-1:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    function void enqueue(sample_t s);
      pending.insert(pending.size(), s);
    endfunction

    function void push_marker(int unsigned bin);
      sample_t s;
      s.tri_idx = '0;
      s.bin = bin[TIME_W-1:0];
      s.energy = '0;
      s.svalid = 1'b0;
      s.last = 1'b1;
      enqueue(s);
    endfunction

    // First source whose link row the next step reads while part of it is unwritten
    function int need_row();
      int unsigned n, dur, t;
      logic [E_W-1:0] total, refl;
      logic [E_W-1:0] row[NTRI];
      n = active_count();
      dur = last_bin();
      t = cur_bin;
      if (t > dur) return -1;
      total = '0;
      for (int i = 0; i < n; i++) begin
        row[i] = arrivals[t*NTRI+i];
        total = add_sat(total, row[i]);
      end
      if (total < bin_floor) return -1;
      for (int i = 0; i < n; i++) begin
        if (row[i] < cell_floor) continue;
        refl = scale(row[i], 17'd65536 - absorb[i]);
        if (refl < cell_floor) continue;
        for (int j = 0; j < n; j++)
          if (j != i && !lk_set[i*NTRI+j]) return i;
        // zero-delay arrivals further up this bin
        for (int j = i + 1; j < n; j++)
          if (lk_vis[i*NTRI+j] && lk_dly[i*NTRI+j] == '0)
            row[j] = add_sat(row[j], scale(refl, lk_share[i*NTRI+j]));
      end
      return -1;
    endfunction

    // One time bin: emit qualifying cells and spread reflected energy, or push the empty marker
    function void predict_bin();
      int unsigned n, dur, t, at, cnt;
      logic [E_W-1:0] total, e, refl;
      sample_t s;
      n = active_count();
      dur = last_bin();
      t = cur_bin;
      steps++;
      if (t > dur) begin
        push_marker(t);
        return;
      end
      cur_bin = t + 1;
      total = '0;
      for (int i = 0; i < n; i++) total = add_sat(total, arrivals[t*NTRI+i]);
      if (total < bin_floor) begin
        push_marker(t);
        return;
      end
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        e = arrivals[t*NTRI+i];
        if (e < cell_floor) continue;
        s.tri_idx = i[TRI_IO_W-1:0];
        s.bin = t[TIME_W-1:0];
        s.energy = e;
        s.svalid = 1'b1;
        s.last = 1'b0;
        enqueue(s);
        cnt++;
        refl = scale(e, 17'd65536 - absorb[i]);
        if (refl < cell_floor) continue;
        for (int j = 0; j < n; j++) begin
          if (j == i || !lk_vis[i*NTRI+j]) continue;
          at = t + lk_dly[i*NTRI+j];
          if (at > dur) continue;
          arrivals[at*NTRI+j] = add_sat(arrivals[at*NTRI+j],
                                        scale(refl, lk_share[i*NTRI+j]));
        end
      end
      if (cnt == 0) push_marker(t);
      else pending[pending.size()-1].last = 1'b1;
    endfunction

    function void note_request(request_t r);
      int unsigned k;
      case (r.op)
        OP_ABS: absorb[r.src] = sat_frac(r.frac);
        OP_LINK: begin
          k = r.src * NTRI + r.tgt;
          lk_vis[k] = r.vis;
          lk_dly[k] = r.dly;
          lk_share[k] = sat_frac(r.frac);
          lk_set[k] = 1'b1;
        end
        OP_SEED: begin
          if (r.src < active_count() && r.stime <= last_bin() && r.energy != '0) begin
            k = r.stime * NTRI + r.src;
            arrivals[k] = add_sat(arrivals[k], r.energy);
          end
        end
        OP_STEP: predict_bin();
        OP_CLEAR: begin
          foreach (arrivals[i]) arrivals[i] = '0;
          cur_bin = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("sample with no expectation: tri %0d bin %0d", got.tri_idx, got.bin);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.tri_idx !== want.tri_idx) begin
        $error("sample_triangle: expected %0d, got %0d", want.tri_idx, got.tri_idx);
        errors++;
      end
      if (got.bin !== want.bin) begin
        $error("sample_time: expected %0d, got %0d", want.bin, got.bin);
        errors++;
      end
      if (got.energy !== want.energy) begin
        $error("sample_energy: expected %0h, got %0h", want.energy, got.energy);
        errors++;
      end
      if (got.svalid !== want.svalid) begin
        $error("sample_valid: expected %0b, got %0b", want.svalid, got.svalid);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_bin: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [E_W-1:0]       cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i = '0;
  logic [TRI_IO_W-1:0]  source_triangle_i = '0;
  logic [TRI_IO_W-1:0]  target_triangle_i = '0;
  logic                 link_visible_i = 1'b0;
  logic [DLY_W-1:0]     link_delay_i = '0;
  logic [FRAC_W-1:0]    fraction_value_i = '0;
  logic [TIME_W-1:0]    seed_time_i = '0;
  logic [E_W-1:0]       seed_energy_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [TRI_IO_W-1:0]  sample_triangle_o;
  logic [TIME_W-1:0]    sample_time_o;
  logic [E_W-1:0]       sample_energy_o;
  logic                 sample_valid_o;
  logic                 last_of_bin_o;

  energy_board board = new();
  bit          rush = 1'b0;
  int unsigned cycles = 0;
  int unsigned requests = 0;
  int unsigned stall_left = 0;

  diffuse_energy_time_propagation i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side backpressure
  always @(negedge clk_i) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rush) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_stall_i <= 1'b0;
      else begin
        out_stall_i <= 1'b1;
        stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 60);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    sample_t s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      s.tri_idx = sample_triangle_o;
      s.bin = sample_time_o;
      s.energy = sample_energy_o;
      s.svalid = sample_valid_o;
      s.last = last_of_bin_o;
      board.check_sample(s);
    end
  end

  function automatic logic [E_W-1:0] rand_energy();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // Random content in every field; callers override what matters
  function automatic request_t noise_request();
    request_t r;
    r.op = OP_W'($urandom_range(0, 7));
    r.src = TRI_IO_W'($urandom_range(0, 63));
    r.tgt = TRI_IO_W'($urandom_range(0, 63));
    r.vis = 1'($urandom_range(0, 1));
    r.dly = DLY_W'($urandom_range(0, 1023));
    r.frac = FRAC_W'($urandom_range(0, 131071));
    r.stime = TIME_W'($urandom_range(0, 1023));
    r.energy = rand_energy();
    return r;
  endfunction

  task automatic send(request_t r);
    int unsigned g, sel;
    sel = $urandom_range(0, 99);
    g = (rush || sel < 60) ? 0 : (sel < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (g) @(negedge clk_i) in_valid_i = 1'b0;
    @(negedge clk_i);
    op_i = r.op;
    source_triangle_i = r.src;
    target_triangle_i = r.tgt;
    link_visible_i = r.vis;
    link_delay_i = r.dly;
    fraction_value_i = r.frac;
    seed_time_i = r.stime;
    seed_energy_i = r.energy;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(r);
    requests++;
  endtask

  task automatic send_op(logic [OP_W-1:0] op);
    request_t r;
    r = noise_request();
    r.op = op;
    send(r);
  endtask

  task automatic send_link(int unsigned s, int unsigned t);
    request_t r;
    r = noise_request();
    r.op = OP_LINK;
    r.src = TRI_IO_W'(s);
    r.tgt = TRI_IO_W'(t);
    if ($urandom_range(0, 3) != 0) r.dly = DLY_W'($urandom_range(0, 6));
    send(r);
  endtask

  task automatic send_seed(int unsigned s, int unsigned t, logic [E_W-1:0] e);
    request_t r;
    r = noise_request();
    r.op = OP_SEED;
    r.src = TRI_IO_W'(s);
    r.stime = TIME_W'(t);
    r.energy = e;
    send(r);
  endtask

  // Every link row that the step will read gets written first
  task automatic step_bin();
    int unsigned n;
    int          row;
    n = board.active_count();
    row = board.need_row();
    while (row >= 0) begin
      for (int j = 0; j < n; j++)
        if (j != row && !board.lk_set[row*NTRI+j]) send_link(row, j);
      row = board.need_row();
    end
    send_op(OP_STEP);
  endtask

  // Wait until every expected sample is out and the block is idle
  task automatic drain();
    @(negedge clk_i) in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (in_stall_o);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic configure(logic [TC_W-1:0] n, logic [TIME_W-1:0] d,
                           logic [E_W-1:0] bf, logic [E_W-1:0] cf);
    cfg_reg_e idx [4] = '{CFG_TRI_COUNT, CFG_DURATION, CFG_BIN_FLOOR, CFG_CELL_FLOOR};
    logic [E_W-1:0] val [4];
    val = '{{41'b0, n}, {38'b0, d}, bf, cf};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_index_i = idx[i];
      cfg_data_i = val[i];
      board.set_reg(idx[i], val[i]);
    end
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  // Random mix, mostly seeds close to the current bin and steps
  task automatic random_phase(int unsigned count);
    int unsigned r, n, t;
    logic [E_W-1:0] e;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      n = board.active_count();
      if (r < 40) begin
        case ($urandom_range(0, 4))
          0: e = rand_energy();
          1: e = {E_W{1'b1}};
          2: e = '0;
          3: e = E_W'($urandom_range(1, 3000));
          default: e = rand_energy() >> $urandom_range(4, 14);
        endcase
        t = ($urandom_range(0, 9) < 7) ? board.cur_bin + $urandom_range(0, 4)
                                       : $urandom_range(0, 1023);
        if (t > 1023) t = 1023;
        send_seed((n > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, 63), t, e);
      end else if (r < 70) step_bin();
      else if (r < 78) send_link($urandom_range(0, 63), $urandom_range(0, 63));
      else if (r < 88) send_op(OP_ABS);
      else if (r < 90) send_op(OP_CLEAR);
      else send_op(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
    end
  endtask

  initial begin
    request_t r;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: absorption extremes, seed rejections, saturation, spare ops
    configure(7'd4, 10'd20, 48'd1100, 48'd110);
    r = noise_request();
    r.op = OP_ABS; r.src = 0; r.frac = '0;
    send(r);
    r.src = 63; r.frac = 17'h1FFFF;
    send(r);
    r.src = 1; r.frac = 17'd65536;
    send(r);
    send_seed(0, 0, {E_W{1'b1}});
    send_seed(0, 0, {E_W{1'b1}});
    send_seed(1, 0, 48'd5000);
    send_seed(2, 0, '0);
    send_seed(4, 0, 48'd9000);
    send_seed(63, 0, 48'd9000);
    send_seed(3, 21, 48'd9000);
    send_seed(3, 1023, 48'd9000);
    send_seed(3, 1, 48'd50);
    step_bin();
    send_op(OP_SPARE_FIRST);
    send_op(OP_SPARE_FIRST + 3'd1);
    send_op(OP_SPARE_LAST);
    step_bin();
    step_bin();
    send_op(OP_CLEAR);
    send_seed(2, 0, 48'd100000);
    step_bin();

    configure(7'd4, 10'd1023, '0, '0);
    random_phase(20);
    configure(7'd1, 10'd0, {E_W{1'b1}}, {E_W{1'b1}});
    random_phase(10);
    configure(7'd0, 10'd3, '0, '0);
    random_phase(6);
    configure(7'd6, 10'd40, rand_energy() >> 8, E_W'($urandom_range(0, 100000)));
    random_phase(20);
    configure(7'd127, 10'd12, 48'd1100, {E_W{1'b1}});
    random_phase(14);
    rush = 1'b1;
    configure(7'd5, 10'd1000, 48'd110, 48'd110);
    random_phase(14);
    rush = 1'b0;
    random_phase(8);

    drain();
    $display("Run covered %0d requests and %0d steps; %0d samples were checked.",
             requests, board.steps, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/detp_pkg.sv
hw/rtl/detp_ctrl.sv
hw/rtl/detp_dp.sv
hw/rtl/diffuse_energy_time_propagation.sv
dv/diffuse_energy_time_propagation_tb.sv
